FILE: hdl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial division prime test block.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   // sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   // which divisor the running division belongs to
   typedef enum logic [1:0] {
      PH_THREE = 2'd0,
      PH_LOW   = 2'd1,
      PH_HIGH  = 2'd2
   } phase_type;

   // status of the shared divider
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // wheel constants
   localparam int SMALL_PRIME_MAX = 3;
   localparam int FIRST_DIVISOR   = 5;
   localparam int WHEEL_STEP      = 6;
   localparam int PAIR_OFFSET     = 2;

   // result transfer width: one flag padded to a byte
   localparam int RSP_TDATA_W = 8;

endpackage

FILE: hdl/tdpt_divider.sv
// ----------------------------------------------------------------------------
// tdpt_divider
// Restoring radix-2 divider, one quotient bit per cycle, quotient and
// remainder held until the next start.
// ----------------------------------------------------------------------------
module tdpt_divider import tdpt_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DATA_WIDTH-1:0] dividend,
   input  logic [DATA_WIDTH-1:0] divisor,
   output div_stat_type          stat,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic [DATA_WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(DATA_WIDTH);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_WIDTH-1:0] num_ff, num_in;
   logic [DATA_WIDTH-1:0] den_ff, den_in;
   logic [DATA_WIDTH-1:0] rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;

   logic [DATA_WIDTH:0]   trial;
   logic [DATA_WIDTH:0]   diff;
   logic                  fits;

   // one shift-subtract step
   assign trial = {rem_ff, num_ff[DATA_WIDTH-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DATA_WIDTH - 1);
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[DATA_WIDTH-2:0], 1'b0};
         quo_in = {quo_ff[DATA_WIDTH-2:0], fits};
         rem_in = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         // last quotient bit
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hdl/trial_division_prime_test.sv
// Values of 3 or less, even values and negatives are decided without any
// division; otherwise the shared restoring divider (one quotient bit per cycle)
// runs once for each trial divisor, up to about the square root of n.
// One item at a time; a new item is taken while the last result waits.
// Reset is synchronous and active high, and clears the sequencer and handshakes.
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division over the 6k +/- 1 wheel, using one
// shared divider under a small sequencer.
// ----------------------------------------------------------------------------
module trial_division_prime_test import tdpt_pkg::*; #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((DATA_WIDTH+7)/8)*8-1:0]      req_tdata,  // candidate
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [RSP_TDATA_W-1:0]               rsp_tdata   // is_prime
);

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic [DATA_WIDTH-1:0] n_ff, n_in;
   logic [DATA_WIDTH-1:0] d_ff, d_in;
   logic                  verdict_ff, verdict_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_bit_ff, rsp_bit_in;

   logic [DATA_WIDTH-1:0] cand;
   logic                  div_start;
   div_stat_type          div_stat;
   logic [DATA_WIDTH-1:0] div_quo;
   logic [DATA_WIDTH-1:0] div_rem;

   assign cand = req_tdata[DATA_WIDTH-1:0];

   // shared divider
   tdpt_divider #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (n_in),
      .divisor   (d_in),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      verdict_in   = verdict_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_bit_in   = rsp_bit_ff;

      // result taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_HOLD;
               priority if (cand[DATA_WIDTH-1] || cand <= DATA_WIDTH'(1)) begin
                  verdict_in = 1'b0;
               end else if (cand <= DATA_WIDTH'(SMALL_PRIME_MAX)) begin
                  verdict_in = 1'b1;
               end else if (!cand[0]) begin
                  verdict_in = 1'b0;
               end else begin
                  // odd and above three: try three first
                  n_in      = cand;
                  d_in      = DATA_WIDTH'(SMALL_PRIME_MAX);
                  phase_in  = PH_THREE;
                  div_start = 1'b1;
                  state_in  = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               unique case (phase_ff)
                  PH_THREE: begin
                     if (div_rem == '0) begin
                        verdict_in = 1'b0;
                        state_in   = ST_HOLD;
                     end else begin
                        d_in      = DATA_WIDTH'(FIRST_DIVISOR);
                        phase_in  = PH_LOW;
                        div_start = 1'b1;
                     end
                  end
                  PH_LOW: begin
                     // divisor past n / d means no factor left
                     priority if (d_ff > div_quo) begin
                        verdict_in = 1'b1;
                        state_in   = ST_HOLD;
                     end else if (div_rem == '0) begin
                        verdict_in = 1'b0;
                        state_in   = ST_HOLD;
                     end else begin
                        d_in      = d_ff + DATA_WIDTH'(PAIR_OFFSET);
                        phase_in  = PH_HIGH;
                        div_start = 1'b1;
                     end
                  end
                  PH_HIGH: begin
                     if (div_rem == '0) begin
                        verdict_in = 1'b0;
                        state_in   = ST_HOLD;
                     end else begin
                        // next wheel position
                        d_in      = d_ff + DATA_WIDTH'(WHEEL_STEP - PAIR_OFFSET);
                        phase_in  = PH_LOW;
                        div_start = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_HOLD: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = verdict_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      phase_ff   <= phase_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      verdict_ff <= verdict_in;
      rsp_bit_ff <= rsp_bit_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-1){1'b0}}, rsp_bit_ff};

   // checks
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside a division");

   a_odd_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> d_ff[0])
      else $error("even trial divisor");

   a_negative: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata[DATA_WIDTH-1])
      |=> (state_ff == ST_HOLD && !verdict_ff))
      else $error("negative candidate not rejected at once");

endmodule
